[src/amo_pkg.sv]
package amo_pkg;

    localparam int MODE_W    = 5;
    localparam int WCODE_W   = 3;
    localparam int REGIDX_W  = 5;
    localparam int ADDR_W    = 12;
    localparam int DATA_W    = 32;
    localparam int FAULT_W   = 2;

    // word index carried by a byte address
    localparam int WORD_INDEX_W = ADDR_W - 2;

    // restoring steps for the wrap of the word index; enough for the
    // smallest store (1024 / 16 = 64 wraps)
    localparam int MOD_STEPS = 6;

    localparam logic [MODE_W-1:0] OP_ADD  = 5'h00;
    localparam logic [MODE_W-1:0] OP_SWAP = 5'h01;
    localparam logic [MODE_W-1:0] OP_LR   = 5'h02;
    localparam logic [MODE_W-1:0] OP_SC   = 5'h03;
    localparam logic [MODE_W-1:0] OP_XOR  = 5'h04;
    localparam logic [MODE_W-1:0] OP_OR   = 5'h08;
    localparam logic [MODE_W-1:0] OP_AND  = 5'h0C;
    localparam logic [MODE_W-1:0] OP_MIN  = 5'h10;
    localparam logic [MODE_W-1:0] OP_MAX  = 5'h14;
    localparam logic [MODE_W-1:0] OP_MINU = 5'h18;
    localparam logic [MODE_W-1:0] OP_MAXU = 5'h1C;

    localparam logic [WCODE_W-1:0] WORD_WIDTH_CODE = 3'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE           = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_ILLEGAL        = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_LOAD_MISALIGN  = 2'd2;
    localparam logic [FAULT_W-1:0] FAULT_STORE_MISALIGN = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [WCODE_W-1:0]  width_code;
        logic [REGIDX_W-1:0] second_reg_index;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   operand;
    } amo_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result_data;
        logic [FAULT_W-1:0] fault;
    } amo_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;    // write one zero word of the clear sweep
        logic capture;  // latch the request and read its word
        logic commit;   // write back, update reservation, load result
    } amo_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
    } amo_status_t;

    function automatic logic known_mode(input logic [MODE_W-1:0] m);
        logic k;
        case (m)
            OP_ADD, OP_SWAP, OP_LR, OP_SC, OP_XOR, OP_OR, OP_AND,
            OP_MIN, OP_MAX, OP_MINU, OP_MAXU: k = 1'b1;
            default:                          k = 1'b0;
        endcase
        return k;
    endfunction

    function automatic logic [DATA_W-1:0] combine(
        input logic [MODE_W-1:0] m,
        input logic [DATA_W-1:0] old,
        input logic [DATA_W-1:0] opd
    );
        logic [DATA_W-1:0] r;
        case (m)
            OP_ADD:  r = old + opd;
            OP_XOR:  r = old ^ opd;
            OP_AND:  r = old & opd;
            OP_OR:   r = old | opd;
            OP_MIN:  r = ($signed(old) > $signed(opd)) ? opd : old;
            OP_MAX:  r = ($signed(old) > $signed(opd)) ? old : opd;
            OP_MINU: r = (old > opd) ? opd : old;
            OP_MAXU: r = (old > opd) ? old : opd;
            default: r = opd; // swap
        endcase
        return r;
    endfunction

endpackage

[src/amo_req_if.sv]
interface amo_req_if import amo_pkg::*;;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [WCODE_W-1:0]  width_code;
    logic [REGIDX_W-1:0] second_reg_index;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   operand;

    modport source (
        output valid, mode, width_code, second_reg_index, address, operand,
        input  ready
    );

    modport sink (
        input  valid, mode, width_code, second_reg_index, address, operand,
        output ready
    );
endinterface

[src/amo_rsp_if.sv]
interface amo_rsp_if import amo_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  result_data;
    logic [FAULT_W-1:0] fault;

    modport source (
        output valid, result_data, fault,
        input  ready
    );

    modport sink (
        input  valid, result_data, fault,
        output ready
    );
endinterface

[src/atomic_memory_op_unit.sv]
// Word atomic unit (RV32A subset: LR, SC, SWAP, ADD, XOR, AND, OR, MIN, MAX,
// MINU, MAXU) against a private store of STORE_WORDS 32-bit words. After
// reset the unit sweeps the store to zero, one word per cycle, so req.ready
// stays low until the sweep ends. From then on the accept cycle reads the
// addressed word from the single-port store; the execute state then combines
// it with the operand, writes it back and loads the result register, waiting
// while that register is full; req.ready returns the cycle after that. A
// result waiting in the output register does not block accepting the next
// request, only its write-back cycle. Faults (illegal encoding, misaligned
// address) return result_data 0 and change neither the store nor the
// reservation. Address bits above the store depth wrap.
module atomic_memory_op_unit import amo_pkg::*;
#(
    parameter int STORE_WORDS = 1024
)
(
    input logic clk,
    input logic rst_n,
    amo_req_if.sink   req,
    amo_rsp_if.source rsp
);

    amo_cmd_t    cmd;
    amo_status_t status;
    amo_req_t    req_word;
    amo_rsp_t    rsp_word;

    assign req_word.mode             = req.mode;
    assign req_word.width_code       = req.width_code;
    assign req_word.second_reg_index = req.second_reg_index;
    assign req_word.address          = req.address;
    assign req_word.operand          = req.operand;

    // sequencer: clear sweep, accept, execute
    amo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // store, reservation, ALU and result register
    amo_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req_word),
        .status (status),
        .rsp    (rsp_word)
    );

    assign rsp.result_data = rsp_word.result_data;
    assign rsp.fault       = rsp_word.fault;

    // no request taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !req.ready)
        else $error("request accepted during clear sweep");

    // capture and write-back never overlap
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !req.ready)
        else $error("second request taken while one executes");

    // every write-back presents a result
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("result not presented after commit");

endmodule

[src/amo_ctrl.sv]
module amo_ctrl import amo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  amo_status_t status,
    output amo_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the word
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/amo_datapath.sv]
module amo_datapath import amo_pkg::*;
#(
    parameter int STORE_WORDS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  amo_cmd_t    cmd,
    input  amo_req_t    req,
    output amo_status_t status,
    output amo_rsp_t    rsp
);

    localparam int IDX_W = $clog2(STORE_WORDS);

    logic [DATA_W-1:0] word_store_mem [STORE_WORDS];

    logic [IDX_W-1:0]    clr_idx_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [WCODE_W-1:0]  wcode_reg;
    logic [REGIDX_W-1:0] rs2_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   operand_reg;
    logic [DATA_W-1:0]   rdata_reg;
    logic                resv_valid_reg;
    logic [ADDR_W-1:0]   resv_addr_reg;
    amo_rsp_t            rsp_reg;

    logic [WORD_INDEX_W-1:0] wrap_rem;
    logic [IDX_W-1:0]        req_idx;

    logic              is_lr, is_sc, illegal, misalign, ok, sc_hit, wr_en;
    logic [FAULT_W-1:0] fault_val;
    logic [DATA_W-1:0]  wr_data, result_val;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;

    // word index modulo store depth by restoring subtraction
    always_comb
    begin
        wrap_rem = req.address[ADDR_W-1:2];
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (32'(wrap_rem) >= (32'(STORE_WORDS) << k))
            begin
                wrap_rem = wrap_rem - WORD_INDEX_W'(32'(STORE_WORDS) << k);
            end
        end
        req_idx = IDX_W'(wrap_rem);
    end

    always_comb
    begin
        is_lr    = (mode_reg == OP_LR);
        is_sc    = (mode_reg == OP_SC);
        illegal  = (wcode_reg != WORD_WIDTH_CODE) || !known_mode(mode_reg)
                   || (is_lr && (rs2_reg != '0));
        misalign = (addr_reg[1:0] != 2'b00);
        if (illegal)
        begin
            fault_val = FAULT_ILLEGAL;
        end
        else if (misalign)
        begin
            fault_val = is_lr ? FAULT_LOAD_MISALIGN : FAULT_STORE_MISALIGN;
        end
        else
        begin
            fault_val = FAULT_NONE;
        end
        ok      = (fault_val == FAULT_NONE);
        sc_hit  = resv_valid_reg && (resv_addr_reg == addr_reg);
        wr_en   = ok && ((is_sc && sc_hit) || (!is_lr && !is_sc));
        wr_data = is_sc ? operand_reg : combine(mode_reg, rdata_reg, operand_reg);
        if (!ok)
        begin
            result_val = '0;
        end
        else if (is_sc)
        begin
            result_val = sc_hit ? DATA_W'(0) : DATA_W'(1);
        end
        else
        begin
            result_val = rdata_reg;
        end
    end

    assign mem_we    = cmd.clear || (cmd.commit && wr_en);
    assign mem_waddr = cmd.clear ? clr_idx_reg : idx_reg;
    assign mem_wdata = cmd.clear ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_store_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rdata_reg <= word_store_mem[req_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg     <= req_idx;
            mode_reg    <= req.mode;
            wcode_reg   <= req.width_code;
            rs2_reg     <= req.second_reg_index;
            addr_reg    <= req.address;
            operand_reg <= req.operand;
        end
        if (cmd.commit)
        begin
            rsp_reg.result_data <= result_val;
            rsp_reg.fault       <= fault_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            resv_valid_reg <= 1'b0;
            resv_addr_reg  <= '0;
        end
        else
        begin
            if (cmd.clear && !status.clear_last)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.commit && ok && is_lr)
            begin
                resv_valid_reg <= 1'b1;
                resv_addr_reg  <= addr_reg;
            end
            else if (cmd.commit && ok && is_sc && sc_hit)
            begin
                resv_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = (clr_idx_reg == IDX_W'(STORE_WORDS - 1));
    assign rsp               = rsp_reg;

endmodule

[verif/atomic_memory_op_unit_test.sv]
`timescale 1ns / 100ps

module atomic_memory_op_unit_test;
    import amo_pkg::*;

    localparam int STORE_WORDS = 1024;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 530;
    localparam int BURST_WORDS = 40;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    // Slowest correct run is the clear sweep plus ~600 words with random gaps
    // on both sides; the limit is several times that.
    localparam int TIMEOUT_NS = 2_000_000;

    // encodings outside the RV32A word subset
    localparam logic [MODE_W-1:0]  BAD_MODE_LOW  = 5'h05;
    localparam logic [MODE_W-1:0]  BAD_MODE_HIGH = 5'h1F;
    localparam logic [WCODE_W-1:0] BAD_WIDTH_MIN = 3'd0;
    localparam logic [WCODE_W-1:0] BAD_WIDTH_MAX = 3'd7;
    localparam logic [ADDR_W-1:0]  TOP_WORD_ADDR = 12'hFFC;
    localparam logic [ADDR_W-1:0]  TOP_BYTE_ADDR = 12'hFFF;

    localparam logic [MODE_W-1:0] AMO_OPS [11] = '{
        OP_ADD, OP_SWAP, OP_LR, OP_SC, OP_XOR, OP_OR, OP_AND,
        OP_MIN, OP_MAX, OP_MINU, OP_MAXU
    };

    logic clk;
    logic rst_n;

    amo_req_if req_bus ();
    amo_rsp_if rsp_bus ();

    atomic_memory_op_unit #(
        .STORE_WORDS(STORE_WORDS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    // Shadow of the unit's architectural state.
    logic [DATA_W-1:0] shadow_store [STORE_WORDS];
    logic              shadow_resv_valid;
    logic [ADDR_W-1:0] shadow_resv_addr;

    // Results predicted at accept time, oldest first.
    amo_rsp_t expected_results [$];

    int  errors;
    int  words_sent;
    int  words_checked;
    int  faults_predicted;
    int  sc_passes;
    bit  idle_off;  // when set neither side inserts gaps

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic bit legal_mode(logic [MODE_W-1:0] m);
        foreach (AMO_OPS[i])
        begin
            if (AMO_OPS[i] == m)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [DATA_W-1:0] apply_op(logic [MODE_W-1:0] m,
                                                   logic [DATA_W-1:0] old_word,
                                                   logic [DATA_W-1:0] opd);
        logic [DATA_W-1:0] nw;
        case (m)
            OP_ADD:  nw = old_word + opd;
            OP_XOR:  nw = old_word ^ opd;
            OP_AND:  nw = old_word & opd;
            OP_OR:   nw = old_word | opd;
            OP_MIN:  nw = ($signed(opd) < $signed(old_word)) ? opd : old_word;
            OP_MAX:  nw = ($signed(opd) < $signed(old_word)) ? old_word : opd;
            OP_MINU: nw = (opd < old_word) ? opd : old_word;
            OP_MAXU: nw = (opd < old_word) ? old_word : opd;
            default: nw = opd;
        endcase
        return nw;
    endfunction

    // Executes one atomic on the shadow state and returns its result.
    function automatic amo_rsp_t execute_atomic(amo_req_t w);
        amo_rsp_t    r;
        int unsigned idx;
        r.result_data = '0;
        r.fault = FAULT_NONE;
        idx = (int'(w.address) >> 2) % STORE_WORDS;
        // width first, then encoding, then LR rs2, then alignment
        if (w.width_code != WORD_WIDTH_CODE || !legal_mode(w.mode))
            r.fault = FAULT_ILLEGAL;
        else if (w.mode == OP_LR)
        begin
            if (w.second_reg_index != '0)
                r.fault = FAULT_ILLEGAL;
            else if (w.address[1:0] != 2'b00)
                r.fault = FAULT_LOAD_MISALIGN;
            else
            begin
                r.result_data = shadow_store[idx];
                shadow_resv_valid = 1'b1;
                shadow_resv_addr = w.address;
            end
        end
        else if (w.address[1:0] != 2'b00)
            r.fault = FAULT_STORE_MISALIGN;
        else if (w.mode == OP_SC)
        begin
            // full 12-bit match; a failed SC keeps the reservation
            if (shadow_resv_valid && shadow_resv_addr == w.address)
            begin
                shadow_store[idx] = w.operand;
                shadow_resv_valid = 1'b0;
                r.result_data = '0;
            end
            else
                r.result_data = 32'd1;
        end
        else
        begin
            r.result_data = shadow_store[idx];
            shadow_store[idx] = apply_op(w.mode, shadow_store[idx], w.operand);
        end
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        if (idle_off)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // Aligned address, biased to a few hot words so state gets reused.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 3))
            0, 1:    a = ADDR_W'($urandom_range(0, 7) * 4);
            2:       a = TOP_WORD_ADDR - ADDR_W'($urandom_range(0, 3) * 4);
            default: a = ADDR_W'($urandom_range(0, 4095));
        endcase
        a[1:0] = 2'b00;
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    // Drive one word onto the request channel, wait for accept, predict.
    task automatic issue_atomic(logic [MODE_W-1:0]   m,
                                logic [WCODE_W-1:0]  wc,
                                logic [REGIDX_W-1:0] rs2,
                                logic [ADDR_W-1:0]   addr,
                                logic [DATA_W-1:0]   opd);
        amo_req_t    w;
        amo_rsp_t    r;
        int unsigned gap;
        w.mode = m;
        w.width_code = wc;
        w.second_reg_index = rs2;
        w.address = addr;
        w.operand = opd;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.mode = w.mode;
        req_bus.width_code = w.width_code;
        req_bus.second_reg_index = w.second_reg_index;
        req_bus.address = w.address;
        req_bus.operand = w.operand;
        req_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_bus.ready);
        r = execute_atomic(w);
        if (r.fault != FAULT_NONE)
            faults_predicted++;
        if (w.mode == OP_SC && r.fault == FAULT_NONE && r.result_data == '0)
            sc_passes++;
        expected_results.push_back(r);
        words_sent++;
    endtask

    task automatic issue_legal(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] opd);
        issue_atomic(m, WORD_WIDTH_CODE, '0, addr, opd);
    endtask

    task automatic check_result(amo_rsp_t got);
        amo_rsp_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected word: result_data %h fault %0d",
                   got.result_data, got.fault);
            errors++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.result_data !== want.result_data)
            begin
                $error("result_data: expected %h actual %h",
                       want.result_data, got.result_data);
                errors++;
            end
            if (got.fault !== want.fault)
            begin
                $error("fault: expected %0d actual %0d", want.fault, got.fault);
                errors++;
            end
            words_checked++;
        end
    endtask

    // Response side: random stall per word, then take and check it.
    initial
    begin
        int unsigned gap;
        amo_rsp_t    got;
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_bus.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp_bus.valid);
            got.result_data = rsp_bus.result_data;
            got.fault = rsp_bus.fault;
            check_result(got);
        end
    end

    // Every operation but LR and SC at the data extremes, starting from the cleared store.
    task automatic test_operations();
        issue_legal(OP_ADD, 12'h000, 32'hFFFF_FFFF);
        issue_legal(OP_ADD, 12'h000, 32'h0000_0001);     // wraps to zero
        issue_legal(OP_SWAP, TOP_WORD_ADDR, 32'h8000_0000);
        issue_legal(OP_MIN, TOP_WORD_ADDR, 32'h7FFF_FFFF);
        issue_legal(OP_MAX, TOP_WORD_ADDR, 32'h7FFF_FFFF);
        issue_legal(OP_MINU, TOP_WORD_ADDR, 32'h0000_0000);
        issue_legal(OP_MAXU, TOP_WORD_ADDR, 32'hFFFF_FFFF);
        issue_legal(OP_XOR, 12'h008, 32'hA5A5_A5A5);
        issue_legal(OP_OR, 12'h008, 32'h5A5A_5A5A);
        issue_legal(OP_AND, 12'h008, 32'h0F0F_0F0F);
        issue_atomic(OP_SWAP, WORD_WIDTH_CODE, 5'd31, 12'h008, 32'h0);
    endtask

    // Encoding and alignment faults, including the order of the checks.
    task automatic test_faults();
        issue_atomic(OP_ADD, BAD_WIDTH_MIN, '0, 12'h000, 32'h1);
        issue_atomic(OP_LR, BAD_WIDTH_MAX, '0, 12'h000, 32'h0);
        issue_atomic(BAD_MODE_LOW, WORD_WIDTH_CODE, '0, 12'h000, 32'h1);
        issue_atomic(BAD_MODE_HIGH, WORD_WIDTH_CODE, '0, TOP_BYTE_ADDR, 32'h1);
        issue_atomic(OP_LR, WORD_WIDTH_CODE, 5'd31, 12'h001, 32'h0); // illegal wins
        issue_atomic(OP_LR, WORD_WIDTH_CODE, '0, 12'h002, 32'h0);
        issue_atomic(OP_SC, WORD_WIDTH_CODE, 5'd7, 12'h003, 32'h0);
        issue_atomic(OP_SWAP, WORD_WIDTH_CODE, '0, TOP_BYTE_ADDR, 32'hFFFF_FFFF);
    endtask

    // Reservation: set, miss on another address, faults keep it, hit clears.
    task automatic test_reservation();
        issue_atomic(OP_SC, WORD_WIDTH_CODE, '0, 12'h010, 32'h1111_1111); // none held
        issue_atomic(OP_LR, WORD_WIDTH_CODE, '0, 12'h010, 32'h0);
        issue_atomic(OP_SC, WORD_WIDTH_CODE, 5'd3, 12'h014, 32'h2222_2222);
        issue_atomic(OP_LR, WORD_WIDTH_CODE, '0, 12'h011, 32'h0);
        issue_atomic(OP_LR, BAD_WIDTH_MIN, '0, 12'h020, 32'h0);
        issue_atomic(OP_SC, WORD_WIDTH_CODE, '0, 12'h010, 32'h3333_3333);
        issue_atomic(OP_SC, WORD_WIDTH_CODE, '0, 12'h010, 32'h4444_4444);
        issue_atomic(OP_LR, WORD_WIDTH_CODE, '0, 12'h010, 32'h0);
    endtask

    // Full rate on both sides.
    task automatic test_back_to_back();
        idle_off = 1'b1;
        repeat (BURST_WORDS)
        begin
            issue_atomic(AMO_OPS[$urandom_range(0, 10)], WORD_WIDTH_CODE, '0,
                         ADDR_W'($urandom_range(0, 3) * 4), pick_operand());
        end
        idle_off = 1'b0;
    endtask

    // Mostly legal atomics and LR/SC sequences, with some raw noise.
    task automatic test_random_mix();
        int                start;
        int unsigned       n_mid;
        logic [ADDR_W-1:0] a;
        logic [MODE_W-1:0] m;
        logic [REGIDX_W-1:0] rs2;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            if ((words_sent - start) % 100 == 0)
                idle_off = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:
                begin
                    issue_atomic(MODE_W'($urandom()), WCODE_W'($urandom()),
                                 REGIDX_W'($urandom()), ADDR_W'($urandom()),
                                 DATA_W'($urandom()));
                end
                1, 2:
                begin
                    a = pick_address();
                    issue_atomic(OP_LR, WORD_WIDTH_CODE, '0, a, DATA_W'($urandom()));
                    n_mid = $urandom_range(0, 2);
                    repeat (n_mid)
                    begin
                        issue_atomic(AMO_OPS[$urandom_range(0, 10)], WORD_WIDTH_CODE,
                                     '0, pick_address(), pick_operand());
                    end
                    if ($urandom_range(0, 3) == 0)
                        a = pick_address();
                    issue_atomic(OP_SC, WORD_WIDTH_CODE, REGIDX_W'($urandom()), a,
                                 pick_operand());
                end
                default:
                begin
                    m = AMO_OPS[$urandom_range(0, 10)];
                    a = pick_address();
                    if ($urandom_range(0, 11) == 0)
                        a[1:0] = 2'($urandom_range(1, 3));
                    rs2 = REGIDX_W'($urandom());
                    if (m == OP_LR && $urandom_range(0, 7) != 0)
                        rs2 = '0;
                    issue_atomic(m, WORD_WIDTH_CODE, rs2, a, pick_operand());
                end
            endcase
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        int waited;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        faults_predicted = 0;
        sc_passes = 0;
        idle_off = 1'b0;
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        shadow_resv_valid = 1'b0;
        shadow_resv_addr = '0;

        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode = '0;
        req_bus.width_code = '0;
        req_bus.second_reg_index = '0;
        req_bus.address = '0;
        req_bus.operand = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // the unit clears its store before taking the first word
        test_operations();
        test_faults();
        test_reservation();
        test_back_to_back();
        test_random_mix();

        @(negedge clk);
        req_bus.valid = 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        // watch for stray words after the last one
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d atomics (%0d faulting, %0d successful SC), %0d checked.",
                 words_sent, faults_predicted, sc_passes, words_checked);
        $display("Mismatches and stray words: %0d", errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

endmodule
